### hw/rtl/cbo_pkg.sv
// ----------------------------------------------------------------------------
// cbo_pkg: shared types and constants of the compass bearing block
// Widths, CORDIC arctangent table and the item passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package cbo_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STAGES   = 24;

  // north fields are one bit narrower than west fields
  localparam int NORTH_W = COORD_WIDTH - 1;
  localparam int WEST_W  = COORD_WIDTH;
  localparam int DN_W    = NORTH_W + 1;
  localparam int DW_W    = WEST_W + 1;

  localparam int GUARD_BITS = 58 - COORD_WIDTH;
  // scaled magnitude below 2^58, cordic gain below 2, plus sign and margin
  localparam int XY_W       = GUARD_BITS + COORD_WIDTH + 3;
  localparam int XPAD       = XY_W - DW_W - GUARD_BITS;
  localparam int YPAD       = XY_W - DN_W - GUARD_BITS;

  localparam int ANG_FRAC = 20;
  localparam int ANG_W    = ANG_FRAC + 12;
  localparam int WHOLE_W  = ANG_W - ANG_FRAC;
  localparam int DEG_W    = 9;

  localparam logic signed [ANG_W-1:0] HALF_TURN      = ANG_W'(180) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] FULL_TURN      = ANG_W'(360) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] BEARING_OFFSET = ANG_W'(450) <<< ANG_FRAC;
  localparam logic [WHOLE_W-1:0]      DEG_PER_TURN   = WHOLE_W'(360);
  localparam logic [DEG_W-1:0]        BEARING_SAME   = DEG_W'(90);

  // atan(2^-i) in degrees, scaled by 2^20 and rounded
  localparam logic signed [ANG_W-1:0] ATAN_Q20 [MAX_STAGES] = '{
    ANG_W'(47185920), ANG_W'(27855475), ANG_W'(14718068), ANG_W'(7471121),
    ANG_W'(3750058),  ANG_W'(1876857),  ANG_W'(938658),   ANG_W'(469357),
    ANG_W'(234682),   ANG_W'(117342),   ANG_W'(58671),    ANG_W'(29335),
    ANG_W'(14668),    ANG_W'(7334),     ANG_W'(3667),     ANG_W'(1833),
    ANG_W'(917),      ANG_W'(458),      ANG_W'(229),      ANG_W'(115),
    ANG_W'(57),       ANG_W'(29),       ANG_W'(14),       ANG_W'(7)
  };

  // clock edges from input transfer to the edge that takes the result
  localparam int RESULT_EDGES = CORDIC_STEPS + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // pre-rotated vector, unscaled
  typedef struct packed {
    logic                   same_pos;
    logic                   half_turn;
    logic signed [DW_W-1:0] x;
    logic signed [DN_W-1:0] y;
  } item_t;

endpackage

`default_nettype wire

### hw/rtl/cbo_front.sv
// ----------------------------------------------------------------------------
// cbo_front: position differences and quadrant classification
// Forms north and west differences, flags equal positions and folds a
// negative west difference into the right half plane.
// ----------------------------------------------------------------------------
`default_nettype none

module cbo_front (
  input  wire logic signed [cbo_pkg::NORTH_W-1:0] current_north_i,
  input  wire logic signed [cbo_pkg::WEST_W-1:0]  current_west_i,
  input  wire logic signed [cbo_pkg::NORTH_W-1:0] target_north_i,
  input  wire logic signed [cbo_pkg::WEST_W-1:0]  target_west_i,
  output cbo_pkg::item_t                          item_o
);

  logic signed [cbo_pkg::DN_W-1:0] dn;
  logic signed [cbo_pkg::DW_W-1:0] dw;

  always_comb begin
    dn = cbo_pkg::DN_W'(target_north_i) - cbo_pkg::DN_W'(current_north_i);
    dw = cbo_pkg::DW_W'(target_west_i) - cbo_pkg::DW_W'(current_west_i);

    item_o.same_pos  = (dn == '0) && (dw == '0);
    item_o.half_turn = dw[cbo_pkg::DW_W-1];
    // negation cannot overflow: differences never reach the most negative code
    if (dw[cbo_pkg::DW_W-1]) begin
      item_o.x = -dw;
      item_o.y = -dn;
    end else begin
      item_o.x = dw;
      item_o.y = dn;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cbo_queue.sv
// ----------------------------------------------------------------------------
// cbo_queue: short first-word-fall-through queue between front and back
// Holds classified items until the cordic pipeline takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module cbo_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  cbo_pkg::item_t push_item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output cbo_pkg::item_t item_o
);

  cbo_pkg::item_t                  mem_q [cbo_pkg::QUEUE_DEPTH];
  logic [cbo_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cbo_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cbo_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == cbo_pkg::QCNT_W'(cbo_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cbo_pkg::QPTR_W'(cbo_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + cbo_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cbo_pkg::QPTR_W'(cbo_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + cbo_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + cbo_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - cbo_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cbo_back.sv
// ----------------------------------------------------------------------------
// cbo_back: unrolled cordic vectoring pipeline and bearing conversion
// One rotation stage per register, then angle wrap and degree conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module cbo_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  input  cbo_pkg::item_t                item_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  output logic [cbo_pkg::DEG_W-1:0]     bearing_degrees_o
);

  localparam int N = cbo_pkg::CORDIC_STEPS;

  logic                              valid_q [N+1];
  logic                              same_q  [N+1];
  logic signed [cbo_pkg::XY_W-1:0]   x_q     [N+1];
  logic signed [cbo_pkg::XY_W-1:0]   y_q     [N+1];
  logic signed [cbo_pkg::ANG_W-1:0]  z_q     [N+1];

  logic                              out_valid_q;
  logic [cbo_pkg::DEG_W-1:0]         bearing_q, bearing_d;

  // the pipeline never stalls, so every waiting item is taken at once
  assign pop_o = item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    same_q[0] <= item_i.same_pos;
    x_q[0]    <= {{cbo_pkg::XPAD{item_i.x[cbo_pkg::DW_W-1]}}, item_i.x,
                  {cbo_pkg::GUARD_BITS{1'b0}}};
    y_q[0]    <= {{cbo_pkg::YPAD{item_i.y[cbo_pkg::DN_W-1]}}, item_i.y,
                  {cbo_pkg::GUARD_BITS{1'b0}}};
    z_q[0]    <= item_i.half_turn ? cbo_pkg::HALF_TURN : '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [cbo_pkg::XY_W-1:0] xs, ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    // rotate toward y = 0
    always_ff @(posedge clk_i) begin
      same_q[i+1] <= same_q[i];
      if (!y_q[i][cbo_pkg::XY_W-1]) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + cbo_pkg::ATAN_Q20[i];
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - cbo_pkg::ATAN_Q20[i];
      end
    end
  end

  logic signed [cbo_pkg::ANG_W-1:0] z_wrap, v;
  logic [cbo_pkg::WHOLE_W-1:0]      whole, reduced;

  always_comb begin
    if (z_q[N] < 0) begin
      z_wrap = z_q[N] + cbo_pkg::FULL_TURN;
    end else if (z_q[N] >= cbo_pkg::FULL_TURN) begin
      z_wrap = z_q[N] - cbo_pkg::FULL_TURN;
    end else begin
      z_wrap = z_q[N];
    end
    v       = cbo_pkg::BEARING_OFFSET - z_wrap;
    whole   = v[cbo_pkg::ANG_W-1:cbo_pkg::ANG_FRAC];
    reduced = (whole >= cbo_pkg::DEG_PER_TURN) ? whole - cbo_pkg::DEG_PER_TURN : whole;
    bearing_d = same_q[N] ? cbo_pkg::BEARING_SAME : reduced[cbo_pkg::DEG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
  end

  assign result_valid_o    = out_valid_q;
  assign bearing_degrees_o = bearing_q;

endmodule

`default_nettype wire

### hw/rtl/compass_bearing_from_offsets.sv
// ----------------------------------------------------------------------------
// compass_bearing_from_offsets: whole-degree bearing between two positions
// Computes (450 - atan2(north diff, west diff)) mod 360 by cordic vectoring.
// ----------------------------------------------------------------------------
// Usage:
//   A query is transferred at a rising edge where start is high and busy is
//   low; the four coordinate ports are sampled at that edge.
//   The front stage forms the differences and classifies the query, a
//   two-entry queue holds it, and the back end runs it through a load
//   register, an unrolled cordic pipeline of CORDIC_STEPS stages and one
//   conversion stage.
//   Result: the result strobe result_valid_o is high for one cycle, with
//   bearing_degrees_o valid in that same cycle.
//   Throughput: one query every cycle; the pipeline never stalls, so the
//   queue drains each cycle and busy stays low in normal operation.
//   The receiver cannot hold results off; every strobe must be taken.
//   Reset clears the queue and all pipeline valid bits; queries in flight
//   are dropped and no strobe follows reset until a new query arrives.
//   Equal positions give a bearing of 90.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_bearing_from_offsets (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [cbo_pkg::NORTH_W-1:0]   current_north_i,
  input  wire logic signed [cbo_pkg::WEST_W-1:0]    current_west_i,
  input  wire logic signed [cbo_pkg::NORTH_W-1:0]   target_north_i,
  input  wire logic signed [cbo_pkg::WEST_W-1:0]    target_west_i,
  output logic                                      result_valid_o,
  output logic [cbo_pkg::DEG_W-1:0]                 bearing_degrees_o
);

  cbo_pkg::item_t front_item, queue_item;
  logic           queue_full, queue_valid, queue_pop;

  cbo_front u_front (
    .current_north_i (current_north_i),
    .current_west_i  (current_west_i),
    .target_north_i  (target_north_i),
    .target_west_i   (target_west_i),
    .item_o          (front_item)
  );

  cbo_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  cbo_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (queue_valid),
    .item_i            (queue_item),
    .pop_o             (queue_pop),
    .result_valid_o    (result_valid_o),
    .bearing_degrees_o (bearing_degrees_o)
  );

  assign busy = queue_full;

endmodule

`default_nettype wire

### hw/rtl/cbo_checker.sv
// ----------------------------------------------------------------------------
// cbo_checker: port-level checks of the compass bearing block
// Fixed latency, no spurious results, range and equal-position bearing.
// ----------------------------------------------------------------------------
`default_nettype none

module cbo_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [cbo_pkg::NORTH_W-1:0]        current_north_i,
  input wire logic [cbo_pkg::WEST_W-1:0]         current_west_i,
  input wire logic [cbo_pkg::NORTH_W-1:0]        target_north_i,
  input wire logic [cbo_pkg::WEST_W-1:0]         target_west_i,
  input wire logic                               result_valid_o,
  input wire logic [cbo_pkg::DEG_W-1:0]          bearing_degrees_o
);

  logic xfer, same_pos;

  assign xfer     = start && !busy;
  assign same_pos = (current_north_i == target_north_i) &&
                    (current_west_i == target_west_i);

  // every transfer yields a result at a fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> ##(cbo_pkg::RESULT_EDGES) result_valid_o)
    else $error("result missing at expected latency");

  // no result without a matching transfer
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(xfer, cbo_pkg::RESULT_EDGES))
    else $error("result without transfer");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (bearing_degrees_o < cbo_pkg::DEG_W'(360)))
    else $error("bearing out of range");

  a_same_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && same_pos) |-> ##(cbo_pkg::RESULT_EDGES)
      (bearing_degrees_o == cbo_pkg::BEARING_SAME))
    else $error("equal positions must give 90");

endmodule

bind compass_bearing_from_offsets cbo_checker u_cbo_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .current_north_i   (current_north_i),
  .current_west_i    (current_west_i),
  .target_north_i    (target_north_i),
  .target_west_i     (target_west_i),
  .result_valid_o    (result_valid_o),
  .bearing_degrees_o (bearing_degrees_o)
);

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of compass_bearing_from_offsets
// Sends position queries through the start/busy command port and checks
// each bearing strobe, in order, against a bit-exact cordic predictor.
// Covers equal positions, cardinal and diagonal offsets, field extremes,
// random in-range positions, nearby position pairs and raw full-width
// coordinates, with random gaps between transfers in all but one nearby-position run.
// ----------------------------------------------------------------------------

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [cbo_pkg::NORTH_W-1:0] north_t;
  typedef logic signed [cbo_pkg::WEST_W-1:0]  west_t;
  typedef logic [cbo_pkg::DEG_W-1:0]          bearing_t;
  typedef int unsigned                        uint_t;

  typedef struct {
    north_t   cur_north;
    west_t    cur_west;
    north_t   tgt_north;
    west_t    tgt_west;
    bearing_t bearing;
  } bearing_query_t;

  localparam int     RESET_CYCLES = 10;
  localparam int     IDLE_PCT     = 26;
  localparam int     MAX_REPORTS  = 10;
  localparam int     STALL_LIMIT  = 1000;
  localparam int     NUM_STAGES   = (cbo_pkg::CORDIC_STEPS > 24) ? 24 : cbo_pkg::CORDIC_STEPS;
  localparam int     ANGLE_FRAC   = 20;
  localparam longint DEG_TURN     = 360;
  localparam longint DEG_HALF     = 180;
  localparam longint DEG_OFFSET   = 450;
  localparam int     SAME_BEARING = 90;
  localparam longint NORTH_LIMIT  = 900000000;
  localparam longint WEST_LIMIT   = 1800000000;

  localparam north_t NORTH_MIN = {1'b1, {(cbo_pkg::NORTH_W-1){1'b0}}};
  localparam north_t NORTH_MAX = {1'b0, {(cbo_pkg::NORTH_W-1){1'b1}}};
  localparam west_t  WEST_MIN  = {1'b1, {(cbo_pkg::WEST_W-1){1'b0}}};
  localparam west_t  WEST_MAX  = {1'b0, {(cbo_pkg::WEST_W-1){1'b1}}};

  // atan(2^-i) in degrees, q20
  localparam longint ARCTAN_Q20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic     clk_i         = 1'b0;
  logic     rst_ni        = 1'b0;
  logic     start         = 1'b0;
  logic     busy;
  north_t   current_north = '0;
  west_t    current_west  = '0;
  north_t   target_north  = '0;
  west_t    target_west   = '0;
  logic     result_valid_o;
  bearing_t bearing_degrees_o;

  bearing_query_t pending_bearings [$];
  int             mismatch_count = 0;
  int             stall_cycles   = 0;
  bit             idle_on        = 1'b1;

  compass_bearing_from_offsets dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .current_north_i  (current_north),
    .current_west_i   (current_west),
    .target_north_i   (target_north),
    .target_west_i    (target_west),
    .result_valid_o   (result_valid_o),
    .bearing_degrees_o(bearing_degrees_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bearing_t predict_bearing(input north_t cn, input west_t cw,
                                               input north_t tn, input west_t tw);
    longint dn, dw, x, y, z, xs, ys, v;
    dn = longint'(tn) - longint'(cn);
    dw = longint'(tw) - longint'(cw);
    if (dn == 0 && dw == 0) begin
      return bearing_t'(SAME_BEARING);
    end
    // west difference is the x axis; left half plane is folded over first
    if (dw < 0) begin
      x = -dw;
      y = -dn;
      z = DEG_HALF <<< ANGLE_FRAC;
    end else begin
      x = dw;
      y = dn;
      z = 0;
    end
    x = x <<< cbo_pkg::GUARD_BITS;
    y = y <<< cbo_pkg::GUARD_BITS;
    for (int i = 0; i < NUM_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q20[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q20[i];
      end
    end
    if (z < 0) z = z + (DEG_TURN <<< ANGLE_FRAC);
    if (z >= (DEG_TURN <<< ANGLE_FRAC)) z = z - (DEG_TURN <<< ANGLE_FRAC);
    v = (DEG_OFFSET <<< ANGLE_FRAC) - z;
    return bearing_t'((v >>> ANGLE_FRAC) % DEG_TURN);
  endfunction

  function automatic north_t rand_north_in_range();
    longint v;
    v = longint'($urandom_range(0, uint_t'(2 * NORTH_LIMIT))) - NORTH_LIMIT;
    return north_t'(v);
  endfunction

  function automatic west_t rand_west_in_range();
    longint v;
    v = longint'($urandom_range(0, uint_t'(2 * WEST_LIMIT))) - WEST_LIMIT;
    return west_t'(v);
  endfunction

  function automatic longint rand_offset(input longint span);
    return longint'($urandom_range(0, uint_t'(2 * span))) - span;
  endfunction

  // one query transfer, with random gaps before it while idle_on is set
  task automatic send_query(input north_t cn, input west_t cw,
                            input north_t tn, input west_t tw);
    bearing_query_t q;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk_i);
      start         <= 1'b0;
      current_north <= north_t'($urandom());
      current_west  <= west_t'($urandom());
      target_north  <= north_t'($urandom());
      target_west   <= west_t'($urandom());
    end
    @(negedge clk_i);
    start         <= 1'b1;
    current_north <= cn;
    current_west  <= cw;
    target_north  <= tn;
    target_west   <= tw;
    do @(posedge clk_i); while (busy);
    q.cur_north = cn;
    q.cur_west  = cw;
    q.tgt_north = tn;
    q.tgt_west  = tw;
    q.bearing   = predict_bearing(cn, cw, tn, tw);
    pending_bearings.push_back(q);
  endtask

  task automatic test_equal_positions();
    send_query('0, '0, '0, '0);
    send_query(NORTH_MAX, WEST_MAX, NORTH_MAX, WEST_MAX);
    send_query(NORTH_MIN, WEST_MIN, NORTH_MIN, WEST_MIN);
    send_query(north_t'(123456789), west_t'(-987654321), north_t'(123456789),
               west_t'(-987654321));
  endtask

  task automatic test_cardinal_and_diagonal();
    send_query('0, '0, north_t'(1000), '0);
    send_query('0, '0, north_t'(-1000), '0);
    send_query('0, '0, '0, west_t'(1000));
    send_query('0, '0, '0, west_t'(-1000));
    send_query('0, '0, north_t'(1000), west_t'(1000));
    send_query('0, '0, north_t'(1000), west_t'(-1000));
    send_query('0, '0, north_t'(-1000), west_t'(1000));
    send_query('0, '0, north_t'(-1000), west_t'(-1000));
    send_query('0, '0, north_t'(1), '0);
    send_query('0, '0, north_t'(-1), west_t'(-1));
  endtask

  task automatic test_coordinate_extremes();
    send_query(north_t'(-NORTH_LIMIT), west_t'(-WEST_LIMIT),
               north_t'(NORTH_LIMIT), west_t'(WEST_LIMIT));
    send_query(north_t'(NORTH_LIMIT), west_t'(WEST_LIMIT),
               north_t'(-NORTH_LIMIT), west_t'(-WEST_LIMIT));
    // full field width, beyond the usual coordinate range
    send_query(NORTH_MIN, WEST_MIN, NORTH_MAX, WEST_MAX);
    send_query(NORTH_MAX, WEST_MAX, NORTH_MIN, WEST_MIN);
    send_query('0, WEST_MIN, '0, WEST_MAX);
    send_query('0, WEST_MAX, '0, WEST_MIN);
    send_query(NORTH_MIN, '0, NORTH_MAX, '0);
    send_query(NORTH_MAX, '0, NORTH_MIN, '0);
  endtask

  task automatic test_random_positions(input int count);
    repeat (count) begin
      send_query(rand_north_in_range(), rand_west_in_range(),
                 rand_north_in_range(), rand_west_in_range());
    end
  endtask

  // target close to the current position, the usual navigation case
  task automatic test_nearby_positions(input int count);
    longint spans [6] = '{0, 1, 16, 1000, 100000, 10000000};
    longint span;
    north_t cn;
    west_t  cw;
    repeat (count) begin
      span = spans[$urandom_range(0, 5)];
      cn   = rand_north_in_range();
      cw   = rand_west_in_range();
      send_query(cn, cw, north_t'(longint'(cn) + rand_offset(span)),
                 west_t'(longint'(cw) + rand_offset(span)));
    end
  endtask

  task automatic test_raw_coordinates(input int count);
    north_t edges_n [4] = '{NORTH_MIN, NORTH_MAX, '0, '1};
    west_t  edges_w [4] = '{WEST_MIN, WEST_MAX, '0, '1};
    north_t cn, tn;
    west_t  cw, tw;
    repeat (count) begin
      cn = north_t'($urandom());
      cw = west_t'($urandom());
      tn = north_t'($urandom());
      tw = west_t'($urandom());
      if ($urandom_range(0, 3) == 0) cn = edges_n[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0) cw = edges_w[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0) tn = edges_n[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0) tw = edges_w[$urandom_range(0, 3)];
      send_query(cn, cw, tn, tw);
    end
  endtask

  always @(posedge clk_i) begin : check_bearings
    bearing_query_t q;
    if (rst_ni && result_valid_o) begin
      if (pending_bearings.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected bearing %0d with no query outstanding", bearing_degrees_o);
        end
        mismatch_count++;
      end else begin
        q = pending_bearings.pop_front();
        if (bearing_degrees_o !== q.bearing) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("bearing mismatch: cur (%0d, %0d) tgt (%0d, %0d) expected %0d got %0d",
                     q.cur_north, q.cur_west, q.tgt_north, q.tgt_west, q.bearing,
                     bearing_degrees_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // no transfer in either direction for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_equal_positions();
    test_cardinal_and_diagonal();
    test_coordinate_extremes();
    test_random_positions(600);
    idle_on = 1'b0;
    test_nearby_positions(300);
    idle_on = 1'b1;
    test_nearby_positions(200);
    test_raw_coordinates(450);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_bearings.size() != 0) @(posedge clk_i);
    repeat (cbo_pkg::RESULT_EDGES + 4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_bearings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
